// ----- sv/piel_pkg.sv -----
// Shared constants, codes and types for the positional insert/erase list.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package piel_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int OP_BITS   = 3;
   localparam int POS_BITS  = 7;
   localparam int ST_BITS   = 2;
   localparam int CMP_BITS  = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

   localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
   localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_BITS-1:0] OP_READ   = 3'd4;
   localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd5;
   localparam logic [OP_BITS-1:0] OP_RESIZE = 3'd6;

   localparam logic [ST_BITS-1:0] ST_OK    = 2'd0;
   localparam logic [ST_BITS-1:0] ST_RANGE = 2'd1;
   localparam logic [ST_BITS-1:0] ST_FULL  = 2'd2;
   localparam logic [ST_BITS-1:0] ST_EMPTY = 2'd3;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [ADDR_BITS-1:0]        addr_type;
   typedef logic [CNT_BITS-1:0]         cnt_type;
   typedef logic [CMP_BITS-1:0]         cmp_type;
   typedef logic [OP_BITS-1:0]          op_type;
   typedef logic [POS_BITS-1:0]         pos_type;
   typedef logic [ST_BITS-1:0]          st_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the request beat
      logic idx_init;    // load the walk index for the current op
      logic idx_step;    // advance the walk index
      logic rd_issue;    // read the RAM
      logic rd_capture;  // keep the RAM data as the read result
      logic wr_shift;    // write the RAM data one slot over
      logic wr_value;    // write the request value
      logic rsp_load;    // commit the count and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      st_type err;        // ST_OK when the request is legal
      logic   scan_more;  // another entry remains to be moved
      logic   fill_more;  // another slot remains to be filled
      logic   out_free;   // the result register can take a new beat
   } stat_type;

endpackage

`default_nettype wire

// ----- sv/piel_ifs.sv -----
// Request and response channel interfaces for the positional insert/erase list.
// Depends on piel_pkg for field widths.
`default_nettype none

interface piel_req_if;
   logic                                valid;
   logic                                ready;
   logic [piel_pkg::OP_BITS-1:0]        op;
   logic [piel_pkg::POS_BITS-1:0]       position;
   logic signed [piel_pkg::WORD_BITS-1:0] value;
   logic [piel_pkg::POS_BITS-1:0]       new_count;

   modport source (output valid, op, position, value, new_count, input ready);
   modport sink   (input valid, op, position, value, new_count, output ready);
endinterface

interface piel_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [piel_pkg::WORD_BITS-1:0] read_value;
   logic [piel_pkg::CNT_BITS-1:0]         count;
   logic [piel_pkg::ST_BITS-1:0]          status;

   modport source (output valid, read_value, count, status, input ready);
   modport sink   (input valid, read_value, count, status, output ready);
endinterface

`default_nettype wire

// ----- sv/piel_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module piel_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- sv/piel_ctrl.sv -----
// Controller state machine for the positional insert/erase list.
// Depends on piel_pkg for the command and status structs and the op codes.
`default_nettype none

module piel_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire piel_pkg::stat_type stat,
   output      piel_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_DECODE    = 7'b0000010,
      S_SHIFT_RD  = 7'b0000100,
      S_SHIFT_WR  = 7'b0001000,
      S_FILL      = 7'b0010000,
      S_READ_WAIT = 7'b0100000,
      S_FINISH    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.err != piel_pkg::ST_OK) begin
               state_in = S_FINISH;
            end else begin
               case (stat.op) inside
                  piel_pkg::OP_PUSH, piel_pkg::OP_WRITE: begin
                     cmd.wr_value = 1'b1;
                     state_in     = S_FINISH;
                  end
                  piel_pkg::OP_INSERT, piel_pkg::OP_ERASE: begin
                     cmd.idx_init = 1'b1;
                     state_in     = S_SHIFT_RD;
                  end
                  piel_pkg::OP_READ: begin
                     cmd.rd_issue = 1'b1;
                     state_in     = S_READ_WAIT;
                  end
                  piel_pkg::OP_RESIZE: begin
                     cmd.idx_init = 1'b1;
                     state_in     = S_FILL;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SHIFT_RD: begin
            if (stat.scan_more) begin
               cmd.rd_issue = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               // Once the tail has moved up, the new word drops into the gap.
               cmd.wr_value = (stat.op == piel_pkg::OP_INSERT);
               state_in     = S_FINISH;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_step = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FILL: begin
            if (stat.fill_more) begin
               cmd.wr_value = 1'b1;
               cmd.idx_step = 1'b1;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_READ_WAIT: begin
            cmd.rd_capture = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/piel_dp.sv -----
// Datapath for the positional insert/erase list: request latch, entry count,
// walk index, entry RAM and result register. Depends on piel_pkg and piel_ram.
`default_nettype none

module piel_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire piel_pkg::cmd_type  cmd,
   output      piel_pkg::stat_type stat,
   input  wire piel_pkg::op_type   req_op,
   input  wire piel_pkg::pos_type  req_position,
   input  wire piel_pkg::word_type req_value,
   input  wire piel_pkg::pos_type  req_new_count,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      piel_pkg::word_type rsp_read_value,
   output      piel_pkg::cnt_type  rsp_count,
   output      piel_pkg::st_type   rsp_status
);

   piel_pkg::op_type   op_ff;
   piel_pkg::pos_type  pos_ff;
   piel_pkg::word_type value_ff;
   piel_pkg::pos_type  target_ff;
   piel_pkg::cnt_type  count_ff, count_in;
   piel_pkg::cnt_type  idx_ff, idx_in;
   piel_pkg::word_type rd_ff;
   logic               rsp_valid_ff;
   piel_pkg::word_type rsp_value_ff;
   piel_pkg::cnt_type  rsp_count_ff;
   piel_pkg::st_type   rsp_status_ff;

   piel_pkg::cmp_type  pos_w, cnt_w, idx_w, tgt_w, depth_w;
   piel_pkg::st_type   err;
   logic               is_insert;

   logic               ram_wr_en;
   piel_pkg::addr_type ram_wr_addr;
   piel_pkg::word_type ram_wr_data;
   piel_pkg::addr_type ram_rd_addr;
   logic [piel_pkg::WORD_BITS-1:0] ram_rd_data;

   assign pos_w     = piel_pkg::cmp_type'(pos_ff);
   assign cnt_w     = piel_pkg::cmp_type'(count_ff);
   assign idx_w     = piel_pkg::cmp_type'(idx_ff);
   assign tgt_w     = piel_pkg::cmp_type'(target_ff);
   assign depth_w   = piel_pkg::cmp_type'(piel_pkg::DEPTH);
   assign is_insert = (op_ff == piel_pkg::OP_INSERT);

   // Legality check; a failing request leaves the list untouched.
   always_comb begin
      err = piel_pkg::ST_OK;
      case (op_ff) inside
         piel_pkg::OP_PUSH: begin
            if (cnt_w >= depth_w) err = piel_pkg::ST_FULL;
         end
         piel_pkg::OP_POP: begin
            if (cnt_w == '0) err = piel_pkg::ST_EMPTY;
         end
         piel_pkg::OP_INSERT: begin
            if (pos_w > cnt_w) begin
               err = piel_pkg::ST_RANGE;
            end else if (cnt_w >= depth_w) begin
               err = piel_pkg::ST_FULL;
            end
         end
         piel_pkg::OP_ERASE, piel_pkg::OP_READ, piel_pkg::OP_WRITE: begin
            if (pos_w >= cnt_w) err = piel_pkg::ST_RANGE;
         end
         piel_pkg::OP_RESIZE: begin
            if (tgt_w > depth_w) err = piel_pkg::ST_FULL;
         end
         default: begin
            err = piel_pkg::ST_OK;
         end
      endcase
   end

   assign stat.op        = op_ff;
   assign stat.err       = err;
   // Insert walks down from the count to the position, erase walks up to the count.
   assign stat.scan_more = is_insert ? (idx_w > pos_w) : (idx_w < cnt_w);
   assign stat.fill_more = (idx_w < tgt_w);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_init) begin
         if (op_ff == piel_pkg::OP_ERASE) begin
            idx_in = piel_pkg::cnt_type'(pos_w + 1'b1);
         end else begin
            idx_in = count_ff;
         end
      end else if (cmd.idx_step) begin
         idx_in = is_insert ? idx_ff - 1'b1 : idx_ff + 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (err == piel_pkg::ST_OK) begin
         case (op_ff) inside
            piel_pkg::OP_PUSH, piel_pkg::OP_INSERT: count_in = count_ff + 1'b1;
            piel_pkg::OP_POP, piel_pkg::OP_ERASE:   count_in = count_ff - 1'b1;
            piel_pkg::OP_RESIZE: count_in = piel_pkg::cnt_type'(tgt_w);
            default:             count_in = count_ff;
         endcase
      end
   end

   // RAM read address: the read position, or the entry that moves next.
   always_comb begin
      if (op_ff == piel_pkg::OP_READ) begin
         ram_rd_addr = pos_ff[piel_pkg::ADDR_BITS-1:0];
      end else if (is_insert) begin
         ram_rd_addr = piel_pkg::addr_type'(idx_ff - 1'b1);
      end else begin
         ram_rd_addr = idx_ff[piel_pkg::ADDR_BITS-1:0];
      end
   end

   always_comb begin
      ram_wr_en   = cmd.wr_shift || cmd.wr_value;
      ram_wr_data = value_ff;
      ram_wr_addr = idx_ff[piel_pkg::ADDR_BITS-1:0];
      if (cmd.wr_shift) begin
         ram_wr_data = piel_pkg::word_type'(ram_rd_data);
         ram_wr_addr = is_insert ? idx_ff[piel_pkg::ADDR_BITS-1:0]
                                 : piel_pkg::addr_type'(idx_ff - 1'b1);
      end else begin
         case (op_ff) inside
            piel_pkg::OP_PUSH:
               ram_wr_addr = count_ff[piel_pkg::ADDR_BITS-1:0];
            piel_pkg::OP_INSERT, piel_pkg::OP_WRITE:
               ram_wr_addr = pos_ff[piel_pkg::ADDR_BITS-1:0];
            default:
               ram_wr_addr = idx_ff[piel_pkg::ADDR_BITS-1:0];
         endcase
      end
   end

   piel_ram #(
      .WIDTH (piel_pkg::WORD_BITS),
      .DEPTH (piel_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_issue),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_op;
         pos_ff    <= req_position;
         value_ff  <= req_value;
         target_ff <= req_new_count;
      end
      idx_ff <= idx_in;
      if (cmd.capture) begin
         rd_ff <= '0;
      end else if (cmd.rd_capture) begin
         rd_ff <= piel_pkg::word_type'(ram_rd_data);
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= rd_ff;
         rsp_count_ff  <= count_in;
         rsp_status_ff <= err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.rsp_load) begin
            count_ff <= count_in;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// ----- sv/positional_insert_erase_list_top.sv -----
// Top level of the positional insert/erase list: controller plus datapath.
// Depends on piel_pkg, piel_ifs, piel_ctrl, piel_dp and piel_ram.
//
//   Channel   Direction  Beat contents
//   req_bus   in         op, position, value, new_count
//   rsp_bus   out        read_value, count, status
//
// Entries live in a single-port-per-direction RAM, one access of each kind per
// cycle. Push, pop, write, the unused op and failed requests pass through decode
// and finish; read adds a wait for the RAM data; insert and erase add a read and
// a write state per entry moved; a resize that passes its check fills slot by slot.
// Reset clears the count and the control state; entry contents are not cleared.
// A finished beat waits in the result register while the next request runs;
// a second result stalls in the controller until the first is taken.
`default_nettype none

module positional_insert_erase_list_top (
   input  wire logic   clock,
   input  wire logic   reset,
   piel_req_if.sink    req_bus,
   piel_rsp_if.source  rsp_bus
);

   piel_pkg::cmd_type  cmd;
   piel_pkg::stat_type stat;

   piel_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   piel_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_bus.op),
      .req_position   (req_bus.position),
      .req_value      (req_bus.value),
      .req_new_count  (req_bus.new_count),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_read_value (rsp_bus.read_value),
      .rsp_count      (rsp_bus.count),
      .rsp_status     (rsp_bus.status)
   );

`ifndef SYNTHESIS
   // An accepted request keeps the controller busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while the previous one was still decoding");

   // A result is never loaded over one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("result register overwritten");

   // The RAM write port is driven by at most one source at a time.
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.wr_shift, cmd.wr_value}))
      else $error("shift and value writes collide");

   // A failed request reports zero and leaves the count in range.
   a_error_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status != piel_pkg::ST_OK) |->
         (rsp_bus.read_value == '0 &&
          rsp_bus.count <= piel_pkg::cnt_type'(piel_pkg::DEPTH)))
      else $error("error beat carries data or a bad count");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_positional_insert_erase_list_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the positional insert/erase list top level.
// Needs piel_pkg, piel_ifs and the RTL under sv/; a shadow list predicts each answer.

module tb_positional_insert_erase_list_top;
   import piel_pkg::*;

   localparam op_type OP_SPARE     = 3'd7;   // selector the block ignores
   localparam int     RANDOM_ITEMS = 1650;
   localparam int     STALL_LIMIT  = 4000;
   localparam int     DRAIN_CYCLES = 150;

   // Shadow copy of the list. Requests are applied in acceptance order and the
   // answers they should produce are queued for the response side.
   class list_shadow;
      typedef struct {
         word_type read_value;
         cnt_type  count;
         st_type   status;
      } answer_type;

      word_type   slots[DEPTH];
      int         fill;
      int         mismatches;
      answer_type expected_answers[$];

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_answers.size();
      endfunction

      function void note_request(op_type op, pos_type pos, word_type val, pos_type target);
         answer_type ans;
         int i;
         ans.read_value = '0;
         ans.status = ST_OK;
         case (op)
            OP_PUSH: begin
               if (fill >= DEPTH) ans.status = ST_FULL;
               else begin
                  slots[fill] = val;
                  fill++;
               end
            end
            OP_POP: begin
               if (fill == 0) ans.status = ST_EMPTY;
               else fill--;
            end
            OP_INSERT: begin
               // Position is judged before capacity.
               if (pos > fill) ans.status = ST_RANGE;
               else if (fill >= DEPTH) ans.status = ST_FULL;
               else begin
                  for (i = fill; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos] = val;
                  fill++;
               end
            end
            OP_ERASE: begin
               if (pos >= fill) ans.status = ST_RANGE;
               else begin
                  for (i = pos; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            OP_READ: begin
               if (pos >= fill) ans.status = ST_RANGE;
               else ans.read_value = slots[pos];
            end
            OP_WRITE: begin
               if (pos >= fill) ans.status = ST_RANGE;
               else slots[pos] = val;
            end
            OP_RESIZE: begin
               if (target > DEPTH) ans.status = ST_FULL;
               else begin
                  for (i = fill; i < target; i++) slots[i] = val;
                  fill = target;
               end
            end
            default: ;
         endcase
         ans.count = cnt_type'(fill);
         expected_answers = {expected_answers, ans};
      endfunction

      function void check_response(word_type rd, cnt_type cnt, st_type st);
         answer_type ans;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response beat: read_value %0d count %0d status %0d",
                     $time, rd, cnt, st);
            mismatches++;
            return;
         end
         ans = expected_answers.pop_front();
         if (rd !== ans.read_value) begin
            $display("%0t: read_value mismatch: expected %0d actual %0d",
                     $time, ans.read_value, rd);
            mismatches++;
         end
         if (cnt !== ans.count) begin
            $display("%0t: count mismatch: expected %0d actual %0d", $time, ans.count, cnt);
            mismatches++;
         end
         if (st !== ans.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d", $time, ans.status, st);
            mismatches++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   bit         no_idle = 1'b0;
   int         quiet_cycles = 0;
   list_shadow shadow = new();

   piel_req_if req_bus();
   piel_rsp_if rsp_bus();

   positional_insert_erase_list_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Called at a falling edge; leaves valid high so back-to-back beats need no gap.
   task automatic send_request(input op_type op, input pos_type pos, input word_type val,
                               input pos_type target);
      while (!no_idle && $urandom_range(99) < 21) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.position  <= pos;
      req_bus.value     <= val;
      req_bus.new_count <= target;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      shadow.note_request(op, pos, val, target);
      @(negedge clock);
   endtask

   task automatic drain_list_answers();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (shadow.pending() != 0) @(negedge clock);
   endtask

   function automatic word_type pick_word();
      case ($urandom_range(19))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3:       return 32'sd0;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Mostly legal positions for the current fill, with some anywhere in the field.
   function automatic pos_type pick_position(bit allow_end);
      int span;
      span = allow_end ? shadow.fill : shadow.fill - 1;
      if (span < 0 || $urandom_range(99) < 15) return pos_type'($urandom_range(127));
      return pos_type'($urandom_range(span));
   endfunction

   function automatic pos_type pick_target();
      int r;
      r = $urandom_range(99);
      if (r < 5) return pos_type'($urandom_range(127));
      if (r < 20) return pos_type'($urandom_range(DEPTH - 1 < shadow.fill + 3 ?
                                                   DEPTH : shadow.fill + 3));
      return pos_type'($urandom_range(DEPTH));
   endfunction

   task automatic send_random_item(output bit ignored);
      int r;
      op_type op;
      r = $urandom_range(99);
      ignored = 1'b0;
      if (r < 18) op = OP_PUSH;
      else if (r < 30) op = OP_POP;
      else if (r < 47) op = OP_INSERT;
      else if (r < 61) op = OP_ERASE;
      else if (r < 74) op = OP_READ;
      else if (r < 85) op = OP_WRITE;
      else if (r < 96) op = OP_RESIZE;
      else begin
         op = OP_SPARE;
         ignored = 1'b1;
      end
      send_request(op, pick_position(op == OP_INSERT), pick_word(), pick_target());
   endtask

   // Response side: ready is redrawn every cycle.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= 21);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         shadow.check_response(rsp_bus.read_value, rsp_bus.count, rsp_bus.status);
   end

   // Watchdog: too many cycles in a row without any beat means the block hung.
   always @(posedge clock) begin
      if (reset || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("positional_insert_erase_list_top regression: fail");
         $finish;
      end
   end

   initial begin
      int  sent;
      bit  ignored;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op = OP_PUSH;
      req_bus.position = '0;
      req_bus.value = '0;
      req_bus.new_count = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corner cases: empty list, append, full list, shrink and clear.
      send_request(OP_POP,    7'd0,   32'sd0,          7'd0);
      send_request(OP_ERASE,  7'd0,   32'sd0,          7'd0);
      send_request(OP_READ,   7'd0,   32'sd0,          7'd0);
      send_request(OP_INSERT, 7'd1,   32'sd5,          7'd0);
      send_request(OP_INSERT, 7'd0,   32'sh7fff_ffff,  7'd0);
      send_request(OP_PUSH,   7'd0,   32'sh8000_0000,  7'd0);
      send_request(OP_INSERT, 7'd2,   -32'sd1,         7'd0);
      send_request(OP_INSERT, 7'd1,   32'sd0,          7'd0);
      send_request(OP_READ,   7'd3,   32'sd0,          7'd0);
      send_request(OP_WRITE,  7'd3,   32'sh1234_5678,  7'd0);
      send_request(OP_WRITE,  7'd4,   32'sd9,          7'd0);
      send_request(OP_ERASE,  7'd1,   32'sd0,          7'd0);
      send_request(OP_RESIZE, 7'd0,   32'sh5a5a_5a5a,  7'd64);
      send_request(OP_PUSH,   7'd0,   32'sd1,          7'd0);
      send_request(OP_INSERT, 7'd64,  32'sd2,          7'd0);
      send_request(OP_INSERT, 7'd127, 32'sd3,          7'd0);
      send_request(OP_WRITE,  7'd63,  32'sh8000_0000,  7'd0);
      send_request(OP_READ,   7'd63,  32'sd0,          7'd0);
      send_request(OP_ERASE,  7'd0,   32'sd0,          7'd0);
      send_request(OP_INSERT, 7'd0,   32'sh0f0f_0f0f,  7'd0);
      send_request(OP_RESIZE, 7'd0,   32'sd0,          7'd65);
      send_request(OP_RESIZE, 7'd0,   32'sd0,          7'd127);
      send_request(OP_ERASE,  7'd63,  32'sd0,          7'd0);
      send_request(OP_RESIZE, 7'd0,   32'sd7,          7'd5);
      send_request(OP_SPARE,  7'd2,   32'sd7,          7'd3);
      send_request(OP_RESIZE, 7'd0,   32'sd0,          7'd0);
      send_request(OP_POP,    7'd0,   32'sd0,          7'd0);
      send_request(OP_READ,   7'd127, 32'sd0,          7'd0);
      drain_list_answers();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // One long stretch with both sides always ready.
         no_idle = (sent >= 500 && sent < 800);
         if (sent == 1000) drain_list_answers();
         send_random_item(ignored);
         if (!ignored) sent++;
      end
      no_idle = 1'b0;

      req_bus.valid <= 1'b0;
      while (shadow.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending() == 0)
         $display("positional_insert_erase_list_top regression: pass");
      else
         $display("positional_insert_erase_list_top regression: fail");
      $finish;
   end

endmodule
